// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== hdl/tfg_pkg.sv =====
// ----------------------------------------------------------------------------
// tfg_pkg
// Constants, register codes and shared types of the turret fire gate.
// ----------------------------------------------------------------------------
package tfg_pkg;

  // angle constants
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [23:0] PI_Q20     = 24'sd3294199;

  // atan(2^-i) at 2^-20 rad
  localparam logic signed [23:0] ATAN_TAB [16] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
    24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
    24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32
  };

  // target kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_OUTPOST = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE_FLAGS   = 3'd0;
  localparam logic [2:0] REG_TOL_PAIR     = 3'd1;
  localparam logic [2:0] REG_JUDGE_DIST   = 3'd2;
  localparam logic [2:0] REG_SPIN_ENTER   = 3'd3;
  localparam logic [2:0] REG_SPIN_EXIT    = 3'd4;
  localparam logic [2:0] REG_STATIC_LIMIT = 3'd5;
  localparam logic [2:0] REG_COMING       = 3'd6;
  localparam logic [2:0] REG_LEAVING      = 3'd7;

  // mode flag bits
  localparam int FLAG_AUTO        = 0;
  localparam int FLAG_SPIN_FORCE  = 1;
  localparam int FLAG_OUTPOST_LCK = 2;
  localparam int FLAG_PHASE_FIRE  = 3;
  localparam int FLAG_STATIC_EN   = 4;
  localparam int FLAG_STATIC_LCK  = 5;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

endpackage

// ===== hdl/tfg_cordic.sv =====
// ----------------------------------------------------------------------------
// tfg_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tfg_cordic import tfg_pkg::*; #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  output cordic_stat_t       stat,
  output logic signed [15:0] angle
);

  localparam logic [3:0] LastStep = 4'(CORDIC_STEPS - 1);

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [23:0] z;
  logic [3:0]         step;
  logic               busy;
  logic               done;
  logic               zero;

  logic signed [32:0] x_ld;
  logic signed [32:0] y_ld;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [23:0] z_rnd;
  logic               y_pos;

  assign x_ld  = {{3{x_in[15]}}, x_in, 14'b0};
  assign y_ld  = {{3{y_in[15]}}, y_in, 14'b0};
  assign xs    = x >>> step;
  assign ys    = y >>> step;
  assign y_pos = !y[32] && (y != '0);
  assign z_rnd = z + 24'sd128;
  assign angle = zero ? 16'sd0 : z_rnd[23:8];
  assign stat  = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        zero <= (x_in == '0) && (y_in == '0);
        // left half plane: turn by pi first
        if (x_in[15]) begin
          x <= -x_ld;
          y <= -y_ld;
          z <= y_in[15] ? -PI_Q20 : PI_Q20;
        end else begin
          x <= x_ld;
          y <= y_ld;
          z <= '0;
        end
      end else if (busy) begin
        if (y_pos) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ATAN_TAB[step];
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ATAN_TAB[step];
        end
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/turret_fire_gate_unit.sv =====
// ----------------------------------------------------------------------------
// turret_fire_gate_unit
// Per-frame fire decision with spin latch, outpost phase window and
// steadiness check.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_ready     | control_on .. gimbal_yaw
//  out      | out_valid / out_ready   | fire, spin_latched
//  cfg      | cfg_we (no wait)        | cfg_index, cfg_data
//
//  One beat at a time: the path is shortest when the gate is closed and
//  longest for a moving outpost, set by the CORDIC rotation loop and the
//  shared 16x16 multiplier (three products).
//  Reset is synchronous; configuration comes back to its defaults.
//  A result held by out_ready does not block the next input beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module turret_fire_gate_unit import tfg_pkg::*; #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               control_on,
  input  logic [1:0]         target_kind,
  input  logic               layer_locked,
  input  logic               static_direct,
  input  logic               tracking,
  input  logic               aim_valid,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] spin_rate,
  input  logic signed [15:0] aim_yaw,
  input  logic signed [15:0] command_yaw,
  input  logic signed [15:0] gimbal_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               fire,
  output logic               spin_latched,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_CORD, S_WRAP, S_LATCH, S_MUL, S_JUDGE, S_CHECK, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [5:0]  mode_flags;
  logic [31:0] tolerance_pair;
  logic [14:0] far_range;
  logic [14:0] spin_enter_speed;
  logic [14:0] spin_exit_speed;
  logic [14:0] static_speed_limit;
  logic [13:0] coming_angle;
  logic [13:0] leaving_angle;

  // captured beat
  logic               c_on;
  logic [1:0]         kind;
  logic               layer;
  logic               sdirect;
  logic               trk;
  logic               aimok;
  logic signed [15:0] tx;
  logic signed [15:0] ty;
  logic signed [15:0] spin;
  logic signed [15:0] aim;
  logic signed [15:0] cmd;
  logic signed [15:0] gim;

  // block state and work registers
  logic signed [15:0] prev_command_yaw;
  logic               spin_fire_latch;
  logic               latch_work;
  logic signed [17:0] ph;
  logic [1:0]         mcnt;
  logic signed [31:0] mul_p;
  logic [31:0]        d2;
  logic [15:0]        tol;
  logic               res_fire;
  logic               res_latch;
  logic               res_upd;

  cordic_stat_t       cord_stat;
  logic signed [15:0] cord_angle;
  logic               cord_start;

  // decision terms
  logic [15:0]        speed;
  logic               aim_held;
  logic               gate_closed;
  logic               is_outpost;
  logic               still_mode;
  logic               need_lock;
  logic               lock_fail;
  logic signed [17:0] phs;
  logic               win_fail;
  logic [16:0]        enter3;
  logic [14:0]        exit_spd;
  logic               latch_calc;
  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [31:0] mul_prod;
  logic signed [16:0] dc;
  logic signed [16:0] dg;
  logic [15:0]        dcmd;
  logic [15:0]        dgim;
  logic               fire_calc;
  logic               out_free;

  assign speed       = spin[15] ? 16'(-spin) : 16'(spin);
  assign aim_held    = trk && aimok;
  assign gate_closed = !c_on || (kind == KIND_NONE) || !mode_flags[FLAG_AUTO];
  assign is_outpost  = (kind == KIND_OUTPOST);
  assign still_mode  = mode_flags[FLAG_STATIC_EN] &&
                       (sdirect || (speed <= {1'b0, static_speed_limit}));
  assign need_lock   = still_mode ? mode_flags[FLAG_STATIC_LCK]
                                  : mode_flags[FLAG_OUTPOST_LCK];
  assign lock_fail   = (need_lock && !layer) || !aim_held;
  assign cord_start  = (state == S_EVAL) && !gate_closed && is_outpost &&
                       !lock_fail && !still_mode;

  // phase is negated for negative spin
  assign phs      = spin[15] ? -ph : ph;
  assign win_fail = (phs < -$signed({4'b0, coming_angle})) ||
                    (phs > $signed({4'b0, leaving_angle}));

  assign enter3   = {2'b0, spin_enter_speed} + {1'b0, spin_enter_speed, 1'b0};
  assign exit_spd = (spin_exit_speed > spin_enter_speed) ? enter3[16:2] : spin_exit_speed;

  always_comb begin
    if (!mode_flags[FLAG_SPIN_FORCE] || !aim_held) begin
      latch_calc = 1'b0;
    end else if (latch_work) begin
      latch_calc = !(speed < {1'b0, exit_spd});
    end else begin
      latch_calc = speed > {1'b0, spin_enter_speed};
    end
  end

  always_comb begin
    case (mcnt)
      2'd0: begin
        mul_a = tx;
        mul_b = tx;
      end
      2'd1: begin
        mul_a = ty;
        mul_b = ty;
      end
      default: begin
        mul_a = $signed({1'b0, far_range});
        mul_b = $signed({1'b0, far_range});
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  assign dc        = {prev_command_yaw[15], prev_command_yaw} - {cmd[15], cmd};
  assign dg        = {gim[15], gim} - {prev_command_yaw[15], prev_command_yaw};
  assign dcmd      = dc[16] ? 16'(-dc) : dc[15:0];
  assign dgim      = dg[16] ? 16'(-dg) : dg[15:0];
  assign fire_calc = ({1'b0, dcmd} < {tol, 1'b0}) && (dgim < tol) && aimok;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && !rst;

  tfg_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (tx),
    .y_in  (ty),
    .stat  (cord_stat),
    .angle (cord_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags         <= 6'd13;
      tolerance_pair     <= '0;
      far_range          <= '0;
      spin_enter_speed   <= 15'd12288;
      spin_exit_speed    <= 15'd9216;
      static_speed_limit <= 15'd154;
      coming_angle       <= 14'd214;
      leaving_angle      <= 14'd3216;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE_FLAGS:   mode_flags         <= cfg_data[5:0];
        REG_TOL_PAIR:     tolerance_pair     <= cfg_data;
        REG_JUDGE_DIST:   far_range          <= cfg_data[14:0];
        REG_SPIN_ENTER:   spin_enter_speed   <= cfg_data[14:0];
        REG_SPIN_EXIT:    spin_exit_speed    <= cfg_data[14:0];
        REG_STATIC_LIMIT: static_speed_limit <= cfg_data[14:0];
        REG_COMING:       coming_angle       <= cfg_data[13:0];
        REG_LEAVING:      leaving_angle      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      prev_command_yaw <= '0;
      spin_fire_latch  <= 1'b0;
    end else begin
      // the finish state reloads the output itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_on    <= control_on;
            kind    <= target_kind;
            layer   <= layer_locked;
            sdirect <= static_direct;
            trk     <= tracking;
            aimok   <= aim_valid;
            tx      <= pos_x;
            ty      <= pos_y;
            spin    <= spin_rate;
            aim     <= aim_yaw;
            cmd     <= command_yaw;
            gim     <= gimbal_yaw;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_fire  <= 1'b0;
          res_latch <= 1'b0;
          res_upd   <= 1'b1;
          if (gate_closed) begin
            res_upd <= 1'b0;
            state   <= S_FINISH;
          end else if (is_outpost && lock_fail) begin
            state <= S_FINISH;
          end else if (is_outpost && still_mode) begin
            latch_work <= 1'b0;
            state      <= S_LATCH;
          end else if (is_outpost) begin
            state <= S_CORD;
          end else begin
            latch_work <= spin_fire_latch;
            state      <= S_LATCH;
          end
        end
        S_CORD: begin
          if (cord_stat.done) begin
            ph    <= {aim[15], aim[15], aim} - {cord_angle[15], cord_angle[15], cord_angle};
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          // bring the phase into (-pi, pi] one turn at a time
          if (ph > PI_Q12) begin
            ph <= ph - TWO_PI_Q12;
          end else if (ph <= -PI_Q12) begin
            ph <= ph + TWO_PI_Q12;
          end else if (win_fail) begin
            state <= S_FINISH;
          end else if (mode_flags[FLAG_PHASE_FIRE]) begin
            res_fire <= 1'b1;
            state    <= S_FINISH;
          end else begin
            latch_work <= spin_fire_latch;
            state      <= S_LATCH;
          end
        end
        S_LATCH: begin
          res_latch <= latch_calc;
          if (latch_calc) begin
            res_fire <= 1'b1;
            state    <= S_FINISH;
          end else begin
            mcnt  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // x^2, then y^2, then judge^2 through the one multiplier
          mul_p <= mul_prod;
          mcnt  <= mcnt + 2'd1;
          if (mcnt == 2'd1) begin
            d2 <= 32'(mul_p);
          end else if (mcnt == 2'd2) begin
            d2    <= d2 + 32'(mul_p);
            state <= S_JUDGE;
          end
        end
        S_JUDGE: begin
          tol   <= (d2 > 32'(mul_p)) ? tolerance_pair[31:16] : tolerance_pair[15:0];
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_fire <= fire_calc;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            fire            <= res_fire;
            spin_latched    <= res_latch;
            spin_fire_latch <= res_latch;
            if (res_upd) begin
              prev_command_yaw <= cmd;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_latch_fire, clk, rst, (out_valid && spin_latched) |-> fire, "latch without fire")
  `ASSERT_NEVER(a_cord_stray, clk, rst, cord_stat.done && (state != S_CORD), "stray CORDIC done")
  `ASSERT_PROP(a_cord_busy, clk, rst, cord_stat.busy |-> !in_ready, "ready while CORDIC runs")

endmodule
